### src/bounded_min_priority_queue_top_assert.svh
// Assertion macros shared by the priority queue RTL.
// No dependencies; the module that includes this header supplies clk and rst_n.
`ifndef BOUNDED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BOUNDED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/bmpq_pkg.sv
// Types and codes for the bounded min-first priority queue.
// No dependencies; used by bmpq_core and bounded_min_priority_queue_top.
`default_nettype none

package bmpq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // One stored pair in the entry memory.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

### src/bounded_min_priority_queue_top.sv
// Channel   | Ports                          | Transfer
// ----------+--------------------------------+------------------------
// input     | in_valid, in_ready, in_data    | insert or delete command
// result    | out_valid, out_ready, out_data | one result per command
//
// Insert of a new entry walks back from the tail past every held entry with larger priority;
// each larger entry moves one slot through the single read port of the entry memory.
// Delete reads the head entry and advances the head. Insert when full or delete when empty
// returns only a status and leaves the entry memory as it is.
// A result sits in the output register; the next command is taken while it waits.
// rst_n is synchronous; the queue is empty after reset, memory contents untouched.
//
// Top level of the bounded min-first priority queue; depends on bmpq_pkg, bmpq_core.
`default_nettype none

module bounded_min_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bmpq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bmpq_pkg::out_item_t      out_data
);

  logic                res_valid;
  logic                res_ready;
  bmpq_pkg::out_item_t res_data;

  logic                out_valid_r;
  bmpq_pkg::out_item_t out_data_r;

  bmpq_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### src/bmpq_core.sv
// Sequencer and entry memory of the priority queue: a sorted circular buffer.
// Depends on bmpq_pkg and bounded_min_priority_queue_top_assert.svh.
`default_nettype none

`include "bounded_min_priority_queue_top_assert.svh"

module bmpq_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bmpq_pkg::in_item_t  in_data,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output bmpq_pkg::out_item_t      res_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int OW = bmpq_pkg::OCC_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_DEL     = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       left_r, left_nxt;
  bmpq_pkg::entry_t    new_r, new_nxt;
  bmpq_pkg::out_item_t res_r, res_nxt;

  bmpq_pkg::entry_t    mem [DEPTH];
  bmpq_pkg::entry_t    rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  bmpq_pkg::entry_t    mem_wd;

  logic [SW-1:0]       tail_sum;
  logic [AW-1:0]       tail_addr;
  logic [AW-1:0]       prev_addr;
  logic [AW-1:0]       head_inc;

  // Slot just behind the last held entry; buffer wraps at DEPTH.
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign prev_addr = (wr_ptr_r == '0) ? LAST_ADDR : wr_ptr_r - 1'b1;
  assign head_inc  = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    left_nxt   = left_r;
    new_nxt    = new_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_wa     = wr_ptr_r;
    mem_wd     = new_r;
    rd_addr    = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.value         = in_data.item_value;
          new_nxt.prio          = in_data.priority_req;
          res_nxt.removed_value = '0;
          res_nxt.status        = bmpq_pkg::ST_DONE;
          res_nxt.occupancy     = OW'(count_r);
          if (in_data.command == bmpq_pkg::CMD_INSERT) begin
            if (count_r == FULL_CNT) begin
              res_nxt.status = bmpq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              wr_ptr_nxt = tail_addr;
              left_nxt   = count_r;
              state_nxt  = S_INS_RD;
            end
          end else if (count_r == '0) begin
            res_nxt.status = bmpq_pkg::ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            // head entry is read at this edge
            state_nxt = S_DEL;
          end
        end
      end
      S_INS_RD: begin
        if (left_r == '0) begin
          mem_we            = 1'b1;
          count_nxt         = count_r + 1'b1;
          res_nxt.occupancy = OW'(count_nxt);
          state_nxt         = S_DONE;
        end else begin
          rd_addr    = prev_addr;
          rd_ptr_nxt = prev_addr;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        // Strictly larger priority moves back one slot; equal ones stay ahead.
        if ($signed(rd_data_r.prio) > $signed(new_r.prio)) begin
          mem_wd     = rd_data_r;
          wr_ptr_nxt = rd_ptr_r;
          left_nxt   = left_r - 1'b1;
          state_nxt  = S_INS_RD;
        end else begin
          count_nxt         = count_r + 1'b1;
          res_nxt.occupancy = OW'(count_nxt);
          state_nxt         = S_DONE;
        end
      end
      S_DEL: begin
        res_nxt.removed_value = rd_data_r.value;
        count_nxt             = count_r - 1'b1;
        res_nxt.occupancy     = OW'(count_nxt);
        head_nxt              = head_inc;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      left_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      left_r   <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  `ASSERT_ALWAYS(a_count_bound, count_r <= FULL_CNT, "entry count above depth")
  `ASSERT_IMPLIES(a_full_status, state_r == S_DONE && res_r.status == bmpq_pkg::ST_FULL, count_r == FULL_CNT, "full status with free slots")
  `ASSERT_IMPLIES(a_left_bound, state_r == S_INS_RD || state_r == S_INS_CMP, left_r <= count_r && count_r < FULL_CNT, "insert scan beyond held entries")
  `ASSERT_NEXT(a_del_count, state_r == S_DEL, count_r == $past(count_r) - 1'b1, "delete did not drop one entry")
  `ASSERT_NEXT(a_done_hold, state_r == S_DONE && !res_ready, state_r == S_DONE && $stable(res_r), "result changed before transfer")

endmodule

`default_nettype wire

### dv/tb_bounded_min_priority_queue_top.sv
// Self-checking testbench for the bounded min-first priority queue.
// Depends on bmpq_pkg and bounded_min_priority_queue_top; an internal predictor
// tracks the sorted entries and checks every result transfer in order.
`default_nettype none

module tb_bounded_min_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_SHOWN = 10;
  localparam logic signed [bmpq_pkg::DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
  localparam logic signed [bmpq_pkg::DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bmpq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bmpq_pkg::out_item_t out_data;

  // predictor state: entries kept sorted, smallest priority at index 0
  logic signed [bmpq_pkg::DATA_W-1:0] held_value [QUEUE_DEPTH];
  logic signed [bmpq_pkg::DATA_W-1:0] held_prio [QUEUE_DEPTH];
  int held_count = 0;

  bmpq_pkg::out_item_t pending_results[$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  items_sent = 0;
  int  insert_count = 0;
  int  delete_count = 0;
  int  full_rejects = 0;
  int  empty_rejects = 0;
  int  peak_occupancy = 0;
  bit  idle_on = 1'b1;
  int  long_hold = 0;

  bounded_min_priority_queue_top #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Works out the result of one accepted command and updates the held entries.
  function automatic bmpq_pkg::out_item_t predict_queue_result(
    input bmpq_pkg::in_item_t cmd);
    bmpq_pkg::out_item_t res;
    int pos;
    res = '0;
    res.status = bmpq_pkg::ST_DONE;
    if (cmd.command == bmpq_pkg::CMD_INSERT) begin
      insert_count++;
      if (held_count >= QUEUE_DEPTH) begin
        res.status = bmpq_pkg::ST_FULL;
        full_rejects++;
      end else begin
        pos = held_count;
        // new entry goes behind every entry with priority <= its own
        for (int i = 0; i < held_count; i++) begin
          if (held_prio[i] > cmd.priority_req) begin
            pos = i;
            break;
          end
        end
        for (int i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_value[pos] = cmd.item_value;
        held_prio[pos] = cmd.priority_req;
        held_count++;
      end
    end else begin
      delete_count++;
      if (held_count == 0) begin
        res.status = bmpq_pkg::ST_EMPTY;
        empty_rejects++;
      end else begin
        res.removed_value = held_value[0];
        for (int i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    if (held_count > peak_occupancy) peak_occupancy = held_count;
    res.occupancy = bmpq_pkg::OCC_W'(held_count);
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  // Result checker: every transfer on the result channel against the oldest expectation.
  always @(posedge clk) begin : check_results
    bmpq_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", -1, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (out_data.removed_value !== want.removed_value)
          note_mismatch("removed_value", want.removed_value, out_data.removed_value);
        if (out_data.status !== want.status)
          note_mismatch("status", want.status, out_data.status);
        if (out_data.occupancy !== want.occupancy)
          note_mismatch("occupancy", want.occupancy, out_data.occupancy);
      end
    end
  end

  // Result receiver: random stalls per result, plus a long hold-off on request.
  initial begin : result_receiver
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_ready <= 1'b0;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
      end
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && long_hold == 0) @(posedge clk);
    end
  end

  // Offers one command, holds it until the transfer, then records the expectation.
  task automatic send_command(input logic cmd,
                              input logic signed [bmpq_pkg::DATA_W-1:0] value,
                              input logic signed [bmpq_pkg::DATA_W-1:0] prio);
    bmpq_pkg::in_item_t item;
    int gap;
    item.command = cmd;
    item.item_value = value;
    item.priority_req = prio;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_queue_result(item));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [bmpq_pkg::DATA_W-1:0] pick_priority(input int mode);
    logic signed [bmpq_pkg::DATA_W-1:0] corner [6];
    corner = '{PRIO_MIN, PRIO_MAX, 32'sd0, -32'sd1, PRIO_MIN + 1, PRIO_MAX - 1};
    case (mode)
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 3))) - 32'sd2;  // dense ties
      2: return corner[$urandom_range(0, 5)];
      default: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
    endcase
  endfunction

  task automatic test_delete_on_empty();
    send_command(bmpq_pkg::CMD_DELETE, 32'sh1234_5678, PRIO_MIN);
  endtask

  // Fill to capacity with extreme and tied priorities, overflow once, pull a few.
  task automatic test_fill_and_overflow();
    logic signed [bmpq_pkg::DATA_W-1:0] prios [QUEUE_DEPTH];
    logic signed [bmpq_pkg::DATA_W-1:0] vals [QUEUE_DEPTH];
    prios = '{PRIO_MAX, PRIO_MIN, 0, -1, 1, 5, 5, 5,
              PRIO_MIN, PRIO_MAX, -100, 100, 0, 7, -7, 3};
    vals = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 11, 21, 22, 23,
             31, 41, 51, 61, 71, 81, 91, 101};
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_command(bmpq_pkg::CMD_INSERT, vals[i], prios[i]);
    send_command(bmpq_pkg::CMD_INSERT, 32'sh5555_aaaa, PRIO_MIN);
    repeat (4) send_command(bmpq_pkg::CMD_DELETE, -32'sd1, PRIO_MAX);
    wait_results_drained();
  endtask

  // Receiver stops for a long stretch while commands keep coming back to back.
  task automatic test_backpressure();
    idle_on = 1'b0;
    long_hold = 120;
    for (int i = 0; i < 40; i++)
      send_command(($urandom_range(0, 3) == 0) ? bmpq_pkg::CMD_DELETE : bmpq_pkg::CMD_INSERT,
                   $urandom, pick_priority(i % 4));
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // Phases that lean toward filling, draining or balance, each with its own
  // priority spread and idling setting.
  task automatic test_random_traffic(input int total);
    int sent;
    int phase_len;
    int insert_pct;
    int pmode;
    logic cmd;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 25;
        default: insert_pct = 55;
      endcase
      pmode = $urandom_range(0, 3);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len && sent < total; i++) begin
        cmd = ($urandom_range(1, 100) <= insert_pct) ? bmpq_pkg::CMD_INSERT
                                                     : bmpq_pkg::CMD_DELETE;
        send_command(cmd, $urandom, pick_priority(pmode));
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_results_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin : run_tests
    int waited;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_delete_on_empty();
    test_fill_and_overflow();
    test_backpressure();
    test_random_traffic(900);
    test_backpressure();
    test_random_traffic(800);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d inserts, %0d deletes), %0d results checked,",
             items_sent, insert_count, delete_count, results_checked);
    $display("%0d full rejections, %0d empty rejections, peak occupancy %0d, %0d mismatches",
             full_rejects, empty_rejects, peak_occupancy, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
